// ----- rtl/bcps_pkg.sv -----
// Shared types and constants for the breath cycle phase and setpoint block.
package bcps_pkg;

  localparam int PRESS_W   = 10;
  localparam int DUR_W     = 16;
  localparam int ELAPSED_W = 8;
  localparam int PHASE_W   = 2;
  localparam int PROD_W    = PRESS_W + DUR_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = DUR_W;

  localparam logic [PHASE_W-1:0] PHASE_RAMP   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_HOLD   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_EXHALE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PEEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INHALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE  = 3'd4;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DUR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/bcps_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module bcps_div (
  input  logic                clk,
  input  logic                rst_n,
  input  bcps_pkg::div_req_t  req,
  output bcps_pkg::div_rsp_t  rsp
);

  localparam int PW  = bcps_pkg::PROD_W;
  localparam int DW  = bcps_pkg::DUR_W;
  localparam int CNW = $clog2(PW + 1);

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]  quo_r, quo_nxt;
  logic [DW-1:0]  dvs_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;

  logic [DW:0]   trial;
  logic [DW+1:0] sub;
  logic          ge;

  always_comb begin
    trial   = {rem_r, quo_r[PW-1]};
    sub     = {1'b0, trial} - {2'b00, dvs_r};
    ge      = ~sub[DW+1];
    rem_nxt = ge ? sub[DW-1:0] : trial[DW-1:0];
    quo_nxt = {quo_r[PW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(PW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/breath_cycle_phase_setpoint.sv -----
// Breath cycle sequencer: phase, pressure setpoint and cycle time per tick.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in_     | in        | in_valid/in_ready  | elapsed_ms
//  out_    | out       | out_valid/out_ready| phase, press_target, time_in_cycle,
//          |           |                    | cycle_restarted
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_data (no read-back)
//
// Steps: a tick outside the ramp, or on a zero-length ramp, goes from accept
// straight to S_DONE, which loads its result into the output register. A
// ramp tick passes S_MUL (multiply), S_START (divider start), S_DIV (26
// quotient bits, then done) and S_DONE (load).
// One request is in work at a time; in_ready is low until its result is
// loaded into the output register, which may still be waiting on out_ready.
// Reset is synchronous, active low: cycle time 0, configuration registers to
// defaults, state idle, output not valid. A stalled output holds its payload;
// work finishes and waits in S_DONE while the output stays full.
module breath_cycle_phase_setpoint #(
  parameter int TIME_WIDTH = 17
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input ticks
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bcps_pkg::ELAPSED_W-1:0]       in_elapsed_ms,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bcps_pkg::PHASE_W-1:0]         out_phase,
  output logic [bcps_pkg::PRESS_W-1:0]         out_press_target,
  output logic [bcps_pkg::DUR_W-1:0]           out_time_in_cycle,
  output logic                                 out_cycle_restarted,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic [bcps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bcps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PW = bcps_pkg::PRESS_W;
  localparam int DW = bcps_pkg::DUR_W;
  // compare width: wide enough for both the count and a duration
  localparam int CW = (TIME_WIDTH > DW) ? TIME_WIDTH : DW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  // configuration registers
  logic [PW-1:0] peep_r, pip_r;
  logic [DW-1:0] ramp_r, inhale_r, cycle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peep_r   <= PW'(50);
      pip_r    <= PW'(200);
      ramp_r   <= DW'(500);
      inhale_r <= DW'(1000);
      cycle_r  <= DW'(3000);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bcps_pkg::REG_PEEP:   peep_r   <= cfg_data[PW-1:0];
        bcps_pkg::REG_PIP:    pip_r    <= cfg_data[PW-1:0];
        bcps_pkg::REG_RAMP:   ramp_r   <= cfg_data;
        bcps_pkg::REG_INHALE: inhale_r <= cfg_data;
        bcps_pkg::REG_CYCLE:  cycle_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t                         state_r;
  logic [TIME_WIDTH-1:0]          count_r;
  logic [bcps_pkg::PHASE_W-1:0]   phase_r;
  logic [PW-1:0]                  set_r;
  logic [DW-1:0]                  time_r;
  logic                           restart_r;
  logic                           neg_r;
  logic [PW-1:0]                  mag_r;
  logic [bcps_pkg::PROD_W-1:0]    prod_r;

  logic                           ovalid_r;
  logic [bcps_pkg::PHASE_W-1:0]   ophase_r;
  logic [PW-1:0]                  oset_r;
  logic [DW-1:0]                  otime_r;
  logic                           orestart_r;

  // tick evaluation, done in the accept cycle
  logic [TIME_WIDTH:0]            sum;
  logic [TIME_WIDTH-1:0]          t_sat;
  logic [CW-1:0]                  t_cw;
  logic                           in_ramp, in_hold, in_exh;
  logic [bcps_pkg::PHASE_W-1:0]   phase_nxt;
  logic [PW-1:0]                  set_nxt;
  logic [TIME_WIDTH-1:0]          count_nxt;
  logic                           restart_nxt;
  logic                           div_nxt;
  logic                           accept;
  logic                           out_free;
  logic [PW-1:0]                  q_lo;
  logic [PW-1:0]                  ramp_set;

  bcps_pkg::div_req_t div_req;
  bcps_pkg::div_rsp_t div_rsp;

  always_comb begin
    sum   = {1'b0, count_r} + (TIME_WIDTH + 1)'(in_elapsed_ms);
    // saturate at the top of the counter
    t_sat = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
    t_cw  = CW'(t_sat);

    in_ramp = t_cw <= CW'(ramp_r);
    in_hold = t_cw <= CW'(inhale_r);
    in_exh  = t_cw <= CW'(cycle_r);

    restart_nxt = 1'b0;
    div_nxt     = 1'b0;
    count_nxt   = t_sat;
    if (in_ramp) begin
      phase_nxt = bcps_pkg::PHASE_RAMP;
      set_nxt   = peep_r;              // zero-length ramp gives PEEP
      div_nxt   = (ramp_r != '0);
    end else if (in_hold) begin
      phase_nxt = bcps_pkg::PHASE_HOLD;
      set_nxt   = pip_r;
    end else if (in_exh) begin
      phase_nxt = bcps_pkg::PHASE_EXHALE;
      set_nxt   = peep_r;
    end else begin
      phase_nxt   = bcps_pkg::PHASE_RAMP;
      set_nxt     = peep_r;
      count_nxt   = '0;
      restart_nxt = 1'b1;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !ovalid_r || out_ready;

  // quotient never exceeds |pip - peep|, so the low bits hold it
  assign q_lo     = div_rsp.quotient[PW-1:0];
  assign ramp_set = neg_r ? (peep_r - q_lo) : (peep_r + q_lo);

  assign div_req.start    = (state_r == S_START);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = ramp_r;

  bcps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      // S_DONE sets valid itself when it loads a new result
      if (ovalid_r && out_ready && (state_r != S_DONE)) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r   <= count_nxt;
            phase_r   <= phase_nxt;
            set_r     <= set_nxt;
            time_r    <= restart_nxt ? '0 : t_cw[DW-1:0];
            restart_r <= restart_nxt;
            neg_r     <= pip_r < peep_r;
            mag_r     <= (pip_r < peep_r) ? (peep_r - pip_r) : (pip_r - peep_r);
            state_r   <= div_nxt ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          prod_r  <= bcps_pkg::PROD_W'(mag_r) * bcps_pkg::PROD_W'(time_r);
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            set_r   <= ramp_set;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            ovalid_r   <= 1'b1;
            ophase_r   <= phase_r;
            oset_r     <= set_r;
            otime_r    <= time_r;
            orestart_r <= restart_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = ovalid_r;
  assign out_phase             = ophase_r;
  assign out_press_target      = oset_r;
  assign out_time_in_cycle     = otime_r;
  assign out_cycle_restarted   = orestart_r;

endmodule

// ----- rtl/bcps_chk.sv -----
// Port-level checker for the breath cycle sequencer, bound to the top level.
module bcps_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bcps_pkg::PHASE_W-1:0]       out_phase,
  input logic [bcps_pkg::PRESS_W-1:0]       out_press_target,
  input logic [bcps_pkg::DUR_W-1:0]         out_time_in_cycle,
  input logic                               out_cycle_restarted
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_press_target)
      && $stable(out_time_in_cycle) && $stable(out_phase))
    else $error("result changed while stalled");

  // restart starts the cycle over at time zero in the ramp
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cycle_restarted |->
      out_time_in_cycle == '0 && out_phase == bcps_pkg::PHASE_RAMP)
    else $error("restart without zero time and ramp phase");

  // one request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a new result only appears after a request was in work
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a request in work");

endmodule

bind breath_cycle_phase_setpoint bcps_chk u_bcps_chk (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_phase             (out_phase),
  .out_press_target      (out_press_target),
  .out_time_in_cycle     (out_time_in_cycle),
  .out_cycle_restarted   (out_cycle_restarted)
);
